// ----- design/fmsp_pkg.sv -----
package fmsp_pkg;

    // fixed point format of speeds, errors and sums
    localparam int FRAC_BITS = 16;

    // motors served by the shared controller
    localparam int MOTORS     = 4;
    localparam int MOTOR_BITS = 2;

    // field and register widths
    localparam int DUTY_BITS     = 10;
    localparam int TARGET_BITS   = 18;
    localparam int LIMIT_BITS    = 20;
    localparam int PGAIN_BITS    = 10;
    localparam int IGAIN_BITS    = 8;
    localparam int DGAIN_BITS    = 8;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 20;
    localparam int OUT_DATA_BITS = 16;

    // datapath widths
    localparam int ERR_BITS   = 24;
    localparam int DER_BITS   = 25;
    localparam int MUL_A_BITS = 25;
    localparam int MUL_B_BITS = 10;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS + 1;
    localparam int INTEG_BITS = 40;
    localparam int ACC_BITS   = 44;

    // speed divider: 2000 in Qf divided by the edge period
    localparam int SPEED_BITS   = 27;
    localparam int DIVISOR_BITS = 15;
    localparam int DIV_STEPS    = SPEED_BITS;
    localparam int DIV_CNT_BITS = 5;
    localparam logic [SPEED_BITS-1:0] DIVIDEND = SPEED_BITS'(2000 << FRAC_BITS);
    // longest period whose speed is not below 0.099
    localparam longint SLOW_PERIOD = 20202;

    // caps of the PID terms
    localparam logic signed [PROD_BITS-1:0]  PROP_CAP  = PROD_BITS'(700 << FRAC_BITS);
    localparam logic signed [INTEG_BITS:0]   INTEG_CAP = (INTEG_BITS+1)'(5 << FRAC_BITS);
    localparam logic signed [INTEG_BITS:0]   INTEG_MIN = {2'b11, {(INTEG_BITS-1){1'b0}}};
    localparam logic signed [DER_BITS-1:0]   DER_CAP   = DER_BITS'(200 << FRAC_BITS);
    localparam logic [ACC_BITS-FRAC_BITS-1:0] DUTY_MAX = (ACC_BITS-FRAC_BITS)'(1023);

    // register reset values
    localparam logic [TARGET_BITS-1:0] TARGET_RST = TARGET_BITS'(78643);
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RST  = LIMIT_BITS'(262144);
    localparam logic [PGAIN_BITS-1:0]  PGAIN_RST  = PGAIN_BITS'(140);
    localparam logic [IGAIN_BITS-1:0]  IGAIN_RST  = IGAIN_BITS'(2);
    localparam logic [DGAIN_BITS-1:0]  DGAIN_RST  = DGAIN_BITS'(50);

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_PGAIN  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_IGAIN  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DGAIN  = 3'd4;

    // input word kinds
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // divider status back to the sequencer
    typedef struct packed {
        logic                  done;
        logic [SPEED_BITS-1:0] quotient;
    } div_stat_t;

endpackage

// ----- design/fmsp_div.sv -----
// Restoring divider, one quotient bit per cycle. Divides the fixed
// dividend (2000 in Qf) by a period of at most 15 bits.
module fmsp_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [fmsp_pkg::DIVISOR_BITS-1:0] divisor,
    output fmsp_pkg::div_stat_t               stat
);

    logic [fmsp_pkg::DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [fmsp_pkg::SPEED_BITS-1:0]   quo_reg, quo_next;
    logic [fmsp_pkg::DIVISOR_BITS-1:0] dvs_reg, dvs_next;
    logic [fmsp_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;

    logic [fmsp_pkg::DIVISOR_BITS:0]   rem_shift;
    logic [fmsp_pkg::DIVISOR_BITS:0]   diff;
    logic                              fits;

    // one shift-subtract step
    always_comb begin
        rem_shift = {rem_reg, quo_reg[fmsp_pkg::SPEED_BITS-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        diff      = rem_shift - {1'b0, dvs_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = '0;
            quo_next  = fmsp_pkg::DIVIDEND;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[fmsp_pkg::DIVISOR_BITS-1:0]
                            : rem_shift[fmsp_pkg::DIVISOR_BITS-1:0];
            quo_next = {quo_reg[fmsp_pkg::SPEED_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fmsp_pkg::DIV_CNT_BITS'(fmsp_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ----- design/fmsp_mul.sv -----
// Shared signed-by-unsigned multiplier, product registered.
module fmsp_mul (
    input  logic                                   aclk,
    input  logic signed [fmsp_pkg::MUL_A_BITS-1:0] a,
    input  logic        [fmsp_pkg::MUL_B_BITS-1:0] b,
    output logic signed [fmsp_pkg::PROD_BITS-1:0]  prod
);

    logic signed [fmsp_pkg::PROD_BITS-1:0] prod_reg, prod_next;

    always_comb begin
        prod_next = fmsp_pkg::PROD_BITS'(a) * fmsp_pkg::PROD_BITS'($signed({1'b0, b}));
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- design/four_motor_speed_pid_unit.sv -----
// Four-motor speed controller sharing one PID datapath. Edge words (tuser
// mode 0) record the period between encoder edges of one motor. Control
// ticks (mode 1) serve the motors in turn 1,2,3,0: speed is 2000/period in
// Q16 (0 for periods above 20202), and below speed_limit one PID step
// updates that motor's duty. A zero period skips straight to the result;
// otherwise the speed is forced to zero or divided out by the 27-step
// restoring divider before the PID step. The PID terms go through one
// shared multiplier and one 44-bit adder. The input is not ready while a
// tick is being worked and takes the next word in the cycle after the
// result is loaded; the result sits in an output register, so edge words
// keep flowing while it waits. m_axis_tlast marks the tick that served
// motor 0.
module four_motor_speed_pid_unit #(
    parameter int STAMP_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input words
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [((STAMP_BITS+7)/8)*8-1:0]          s_axis_tdata,  // stamp
    input  logic [2:0]                               s_axis_tuser,  // mode, motor_sel
    // result words
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [fmsp_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,  // motor_id, duty
    output logic                                     m_axis_tuser,  // updated
    output logic                                     m_axis_tlast,  // round_end
    // configuration
    input  logic                                     cfg_we,
    input  logic [fmsp_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
    input  logic [fmsp_pkg::CFG_DATA_BITS-1:0]       cfg_wdata
);

    // period width for the compares, never narrower than the divisor
    localparam int PW = ((STAMP_BITS > fmsp_pkg::DIVISOR_BITS) ? STAMP_BITS
                                                              : fmsp_pkg::DIVISOR_BITS) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_DIV, S_CHECK, S_MULP, S_MULI, S_MULD,
        S_ADDI, S_ADDD, S_CLAMP, S_DONE
    } state_t;

    typedef logic [STAMP_BITS-1:0]                      stamp_t;
    typedef logic signed [fmsp_pkg::INTEG_BITS-1:0]     integ_t;
    typedef logic signed [fmsp_pkg::ERR_BITS-1:0]       err_t;
    typedef logic [fmsp_pkg::DUTY_BITS-1:0]             duty_t;

    state_t state_reg, state_next;

    // configuration
    logic [fmsp_pkg::TARGET_BITS-1:0] target_reg, target_next;
    logic [fmsp_pkg::LIMIT_BITS-1:0]  limit_reg, limit_next;
    logic [fmsp_pkg::PGAIN_BITS-1:0]  pgain_reg, pgain_next;
    logic [fmsp_pkg::IGAIN_BITS-1:0]  igain_reg, igain_next;
    logic [fmsp_pkg::DGAIN_BITS-1:0]  dgain_reg, dgain_next;

    // per-motor state
    stamp_t last_stamp_reg [fmsp_pkg::MOTORS];
    stamp_t last_stamp_next[fmsp_pkg::MOTORS];
    stamp_t period_reg     [fmsp_pkg::MOTORS];
    stamp_t period_next    [fmsp_pkg::MOTORS];
    integ_t integ_reg      [fmsp_pkg::MOTORS];
    integ_t integ_next     [fmsp_pkg::MOTORS];
    err_t   prev_err_reg   [fmsp_pkg::MOTORS];
    err_t   prev_err_next  [fmsp_pkg::MOTORS];
    duty_t  duty_reg       [fmsp_pkg::MOTORS];
    duty_t  duty_next      [fmsp_pkg::MOTORS];

    logic [fmsp_pkg::MOTOR_BITS-1:0] ptr_reg, ptr_next;
    logic                            wrap_reg, wrap_next;
    logic                            upd_reg, upd_next;

    // working registers of one tick
    logic [fmsp_pkg::SPEED_BITS-1:0]      speed_reg, speed_next;
    err_t                                 err_reg, err_next;
    logic signed [fmsp_pkg::DER_BITS-1:0] der_reg, der_next;
    logic signed [fmsp_pkg::ACC_BITS-1:0] acc_reg, acc_next;

    // output register
    logic                                 m_valid_reg, m_valid_next;
    logic [fmsp_pkg::MOTOR_BITS-1:0]      out_id_reg, out_id_next;
    duty_t                                out_duty_reg, out_duty_next;
    logic                                 out_upd_reg, out_upd_next;
    logic                                 out_last_reg, out_last_next;

    // shared units
    logic                                   div_start;
    logic [fmsp_pkg::DIVISOR_BITS-1:0]      div_divisor;
    fmsp_pkg::div_stat_t                    div_stat;
    logic signed [fmsp_pkg::MUL_A_BITS-1:0] mul_a;
    logic [fmsp_pkg::MUL_B_BITS-1:0]        mul_b;
    logic signed [fmsp_pkg::PROD_BITS-1:0]  prod;

    // input fields
    logic                            in_mode;
    logic [fmsp_pkg::MOTOR_BITS-1:0] in_sel;
    stamp_t                          in_stamp;

    // helpers
    logic [fmsp_pkg::MOTOR_BITS:0]          ptr_plus;
    logic [PW-1:0]                          p_wide;
    err_t                                   err_c;
    logic signed [fmsp_pkg::DER_BITS-1:0]   der_c;
    logic signed [fmsp_pkg::INTEG_BITS:0]   integ_sum;
    logic [fmsp_pkg::ACC_BITS-fmsp_pkg::FRAC_BITS-1:0] whole;

    assign in_mode  = s_axis_tuser[0];
    assign in_sel   = s_axis_tuser[2:1];
    assign in_stamp = s_axis_tdata[STAMP_BITS-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = fmsp_pkg::OUT_DATA_BITS'({out_duty_reg, out_id_reg});
    assign m_axis_tuser  = out_upd_reg;
    assign m_axis_tlast  = out_last_reg;

    fmsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (div_divisor),
        .stat    (div_stat)
    );

    fmsp_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // multiplier operand select: issued in the state before the product is used
    always_comb begin
        case (state_reg)
            S_CHECK: begin
                mul_a = fmsp_pkg::MUL_A_BITS'(err_c);
                mul_b = pgain_reg;
            end
            S_MULP: begin
                mul_a = fmsp_pkg::MUL_A_BITS'(err_reg);
                mul_b = fmsp_pkg::MUL_B_BITS'(igain_reg);
            end
            S_MULI: begin
                mul_a = der_reg;
                mul_b = fmsp_pkg::MUL_B_BITS'(dgain_reg);
            end
            default: begin
                mul_a = fmsp_pkg::MUL_A_BITS'(err_reg);
                mul_b = pgain_reg;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        ptr_plus    = {1'b0, ptr_reg} + 1'b1;
        p_wide      = PW'(period_reg[ptr_reg]);
        div_divisor = fmsp_pkg::DIVISOR_BITS'(p_wide);
        err_c       = $signed(fmsp_pkg::ERR_BITS'(target_reg))
                    - $signed(fmsp_pkg::ERR_BITS'(speed_reg[fmsp_pkg::LIMIT_BITS-1:0]));
        der_c       = fmsp_pkg::DER_BITS'(err_c) - fmsp_pkg::DER_BITS'(prev_err_reg[ptr_reg]);
        integ_sum   = (fmsp_pkg::INTEG_BITS+1)'(integ_reg[ptr_reg])
                    + (fmsp_pkg::INTEG_BITS+1)'(prod);
        whole       = acc_reg[fmsp_pkg::ACC_BITS-1:fmsp_pkg::FRAC_BITS];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        target_next     = target_reg;
        limit_next      = limit_reg;
        pgain_next      = pgain_reg;
        igain_next      = igain_reg;
        dgain_next      = dgain_reg;
        last_stamp_next = last_stamp_reg;
        period_next     = period_reg;
        integ_next      = integ_reg;
        prev_err_next   = prev_err_reg;
        duty_next       = duty_reg;
        ptr_next        = ptr_reg;
        wrap_next       = wrap_reg;
        upd_next        = upd_reg;
        speed_next      = speed_reg;
        err_next        = err_reg;
        der_next        = der_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg;
        out_id_next     = out_id_reg;
        out_duty_next   = out_duty_reg;
        out_upd_next    = out_upd_reg;
        out_last_next   = out_last_reg;
        div_start       = 1'b0;

        // register writes
        if (cfg_we) begin
            case (cfg_addr)
                fmsp_pkg::CFG_TARGET: target_next = cfg_wdata[fmsp_pkg::TARGET_BITS-1:0];
                fmsp_pkg::CFG_LIMIT:  limit_next  = cfg_wdata[fmsp_pkg::LIMIT_BITS-1:0];
                fmsp_pkg::CFG_PGAIN:  pgain_next  = cfg_wdata[fmsp_pkg::PGAIN_BITS-1:0];
                fmsp_pkg::CFG_IGAIN:  igain_next  = cfg_wdata[fmsp_pkg::IGAIN_BITS-1:0];
                fmsp_pkg::CFG_DGAIN:  dgain_next  = cfg_wdata[fmsp_pkg::DGAIN_BITS-1:0];
                default: ;
            endcase
        end

        // result word taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_mode == fmsp_pkg::MODE_TICK) begin
                        // advance round-robin pointer
                        if (ptr_plus == (fmsp_pkg::MOTOR_BITS+1)'(fmsp_pkg::MOTORS)) begin
                            ptr_next  = '0;
                            wrap_next = 1'b1;
                        end else begin
                            ptr_next  = ptr_plus[fmsp_pkg::MOTOR_BITS-1:0];
                            wrap_next = 1'b0;
                        end
                        state_next = S_LOAD;
                    end else if ({1'b0, in_sel} <
                                 (fmsp_pkg::MOTOR_BITS+1)'(fmsp_pkg::MOTORS)) begin
                        // encoder edge: period since last edge
                        period_next[in_sel]     = in_stamp - last_stamp_reg[in_sel];
                        last_stamp_next[in_sel] = in_stamp;
                    end
                end
            end
            S_LOAD: begin
                if (p_wide == '0) begin
                    upd_next   = 1'b0;
                    state_next = S_DONE;
                end else if (p_wide > PW'(fmsp_pkg::SLOW_PERIOD)) begin
                    speed_next = '0;
                    state_next = S_CHECK;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    speed_next = div_stat.quotient;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (speed_reg >= fmsp_pkg::SPEED_BITS'(limit_reg)) begin
                    upd_next   = 1'b0;
                    state_next = S_DONE;
                end else if (target_reg == '0 && speed_reg == '0) begin
                    // stopped with zero setpoint: force duty off
                    upd_next           = 1'b1;
                    duty_next[ptr_reg] = '0;
                    state_next         = S_DONE;
                end else begin
                    upd_next   = 1'b1;
                    err_next   = err_c;
                    der_next   = (der_c > fmsp_pkg::DER_CAP) ? fmsp_pkg::DER_CAP : der_c;
                    state_next = S_MULP;
                end
            end
            S_MULP: begin
                // proportional term, capped above
                acc_next   = fmsp_pkg::ACC_BITS'((prod > fmsp_pkg::PROP_CAP)
                                                 ? fmsp_pkg::PROP_CAP : prod);
                state_next = S_MULI;
            end
            S_MULI: begin
                // integral update with saturation both ways
                if (integ_sum > fmsp_pkg::INTEG_CAP) begin
                    integ_next[ptr_reg] = fmsp_pkg::INTEG_BITS'(fmsp_pkg::INTEG_CAP);
                end else if (integ_sum < fmsp_pkg::INTEG_MIN) begin
                    integ_next[ptr_reg] = fmsp_pkg::INTEG_BITS'(fmsp_pkg::INTEG_MIN);
                end else begin
                    integ_next[ptr_reg] = fmsp_pkg::INTEG_BITS'(integ_sum);
                end
                prev_err_next[ptr_reg] = err_reg;
                state_next             = S_MULD;
            end
            S_MULD: begin
                acc_next   = acc_reg + fmsp_pkg::ACC_BITS'(prod);
                state_next = S_ADDI;
            end
            S_ADDI: begin
                acc_next   = acc_reg + fmsp_pkg::ACC_BITS'(integ_reg[ptr_reg]);
                state_next = S_ADDD;
            end
            S_ADDD: begin
                acc_next   = $signed(acc_reg + fmsp_pkg::ACC_BITS'(
                                 {duty_reg[ptr_reg], {fmsp_pkg::FRAC_BITS{1'b0}}}));
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                if (acc_reg <= 0) begin
                    duty_next[ptr_reg] = '0;
                end else if (whole > fmsp_pkg::DUTY_MAX) begin
                    duty_next[ptr_reg] = fmsp_pkg::DUTY_BITS'(fmsp_pkg::DUTY_MAX);
                end else begin
                    duty_next[ptr_reg] = whole[fmsp_pkg::DUTY_BITS-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // hand result to the output register once it is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    out_id_next   = ptr_reg;
                    out_duty_next = duty_reg[ptr_reg];
                    out_upd_next  = upd_reg;
                    out_last_next = wrap_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and per-motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            target_reg  <= fmsp_pkg::TARGET_RST;
            limit_reg   <= fmsp_pkg::LIMIT_RST;
            pgain_reg   <= fmsp_pkg::PGAIN_RST;
            igain_reg   <= fmsp_pkg::IGAIN_RST;
            dgain_reg   <= fmsp_pkg::DGAIN_RST;
            ptr_reg     <= '0;
            wrap_reg    <= 1'b0;
            upd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < fmsp_pkg::MOTORS; i++) begin
                last_stamp_reg[i] <= '0;
                period_reg[i]     <= '0;
                integ_reg[i]      <= '0;
                prev_err_reg[i]   <= '0;
                duty_reg[i]       <= '0;
            end
        end else begin
            state_reg      <= state_next;
            target_reg     <= target_next;
            limit_reg      <= limit_next;
            pgain_reg      <= pgain_next;
            igain_reg      <= igain_next;
            dgain_reg      <= dgain_next;
            ptr_reg        <= ptr_next;
            wrap_reg       <= wrap_next;
            upd_reg        <= upd_next;
            m_valid_reg    <= m_valid_next;
            last_stamp_reg <= last_stamp_next;
            period_reg     <= period_next;
            integ_reg      <= integ_next;
            prev_err_reg   <= prev_err_next;
            duty_reg       <= duty_next;
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        speed_reg    <= speed_next;
        err_reg      <= err_next;
        der_reg      <= der_next;
        acc_reg      <= acc_next;
        out_id_reg   <= out_id_next;
        out_duty_reg <= out_duty_next;
        out_upd_reg  <= out_upd_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- design/fmsp_checker.sv -----
// Port-level checks of the speed controller.
module fmsp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [2:0]                         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fmsp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                               m_axis_tuser,
    input logic                               m_axis_tlast
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // the round ends exactly on the tick that serves motor 0
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd0)))
        else $error("round end flag does not match motor id");

    // a control tick occupies the sequencer
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == fmsp_pkg::MODE_TICK)
            |=> !s_axis_tready)
        else $error("input ready right after a control tick");

    // after an edge word the input is ready again in the next cycle
    a_edge_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == fmsp_pkg::MODE_EDGE)
            |=> s_axis_tready)
        else $error("input stalled after an edge word");

endmodule

bind four_motor_speed_pid_unit fmsp_checker u_fmsp_checker (.*);

// ----- tb/speed_pid_checker.sv -----
// Watches the input, result and configuration ports of the speed controller.
// Keeps its own copy of the per-motor state, predicts the result word of every
// control tick, and compares each result word with the oldest prediction.
module speed_pid_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [15:0]                          s_axis_tdata,  // stamp
    input  logic [2:0]                           s_axis_tuser,  // mode, motor_sel
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [fmsp_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,  // motor_id, duty
    input  logic                                 m_axis_tuser,  // updated
    input  logic                                 m_axis_tlast,  // round_end
    input  logic                                 cfg_we,
    input  logic [fmsp_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [fmsp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output int                                   fail_count,
    output int                                   results_due
);

    typedef struct packed {
        logic [fmsp_pkg::MOTOR_BITS-1:0] motor_id;
        logic [fmsp_pkg::DUTY_BITS-1:0]  duty;
        logic                            updated;
        logic                            round_end;
    } duty_word_t;

    // fixed point bounds of the PID terms
    localparam longint Q_ONE   = longint'(1) << fmsp_pkg::FRAC_BITS;
    localparam longint P_CEIL  = 700 * Q_ONE;
    localparam longint I_CEIL  = 5 * Q_ONE;
    localparam longint I_FLOOR = -(longint'(1) << 39);
    localparam longint D_CEIL  = 200 * Q_ONE;
    localparam longint DUTY_TOP = 1023;

    // register copies
    logic [fmsp_pkg::TARGET_BITS-1:0] target_q;
    logic [fmsp_pkg::LIMIT_BITS-1:0]  limit_q;
    logic [fmsp_pkg::PGAIN_BITS-1:0]  pgain_q;
    logic [fmsp_pkg::IGAIN_BITS-1:0]  igain_q;
    logic [fmsp_pkg::DGAIN_BITS-1:0]  dgain_q;

    // per-motor state
    logic [15:0]                     last_stamp [fmsp_pkg::MOTORS];
    logic [15:0]                     period_of  [fmsp_pkg::MOTORS];
    longint                          integ_of   [fmsp_pkg::MOTORS];
    longint                          last_err   [fmsp_pkg::MOTORS];
    logic [fmsp_pkg::DUTY_BITS-1:0]  duty_of    [fmsp_pkg::MOTORS];
    logic [fmsp_pkg::MOTOR_BITS-1:0] turn;

    duty_word_t duty_expect_q[$];
    duty_word_t got_word;
    duty_word_t want_word;
    int         mismatches;

    assign fail_count = mismatches;

    // one control tick: advance the turn, derive speed, run the PID step
    function automatic duty_word_t serve_tick();
        duty_word_t                      w;
        logic [fmsp_pkg::MOTOR_BITS-1:0] m;
        longint                          p;
        longint                          speed;
        longint                          err;
        longint                          prop;
        longint                          der;
        longint                          sum;
        longint                          whole;
        w.round_end = (turn == fmsp_pkg::MOTOR_BITS'(fmsp_pkg::MOTORS - 1));
        m = w.round_end ? '0 : turn + 1'b1;
        turn = m;
        w.updated = 1'b0;
        p = longint'(period_of[m]);
        if (p != 0) begin
            // speeds under 0.099 read as standing still
            if (99 * p > 2000000)
                speed = 0;
            else
                speed = (longint'(2000) << fmsp_pkg::FRAC_BITS) / p;
            if (speed < longint'(limit_q)) begin
                w.updated = 1'b1;
                if (target_q != 0 || speed != 0) begin
                    err  = longint'(target_q) - speed;
                    prop = err * longint'(pgain_q);
                    der  = err - last_err[m];
                    integ_of[m] = integ_of[m] + err * longint'(igain_q);
                    last_err[m] = err;
                    if (prop > P_CEIL) prop = P_CEIL;
                    if (integ_of[m] > I_CEIL) integ_of[m] = I_CEIL;
                    if (integ_of[m] < I_FLOOR) integ_of[m] = I_FLOOR;
                    if (der > D_CEIL) der = D_CEIL;
                    sum = prop + integ_of[m] + der * longint'(dgain_q)
                        + (longint'(duty_of[m]) << fmsp_pkg::FRAC_BITS);
                    if (sum <= 0) begin
                        duty_of[m] = '0;
                    end else begin
                        whole = sum >>> fmsp_pkg::FRAC_BITS;
                        duty_of[m] = (whole > DUTY_TOP) ? fmsp_pkg::DUTY_BITS'(DUTY_TOP)
                                                        : fmsp_pkg::DUTY_BITS'(whole);
                    end
                end else begin
                    // standing still with a zero setpoint: duty forced off
                    duty_of[m] = '0;
                end
            end
        end
        w.motor_id = m;
        w.duty     = duty_of[m];
        return w;
    endfunction

    task automatic compare_word(input duty_word_t got, input duty_word_t want);
        if (got.motor_id !== want.motor_id) begin
            $error("motor_id: expected %0d, got %0d", want.motor_id, got.motor_id);
            mismatches++;
        end
        if (got.duty !== want.duty) begin
            $error("duty (motor %0d): expected %0d, got %0d",
                   want.motor_id, want.duty, got.duty);
            mismatches++;
        end
        if (got.updated !== want.updated) begin
            $error("updated (motor %0d): expected %0d, got %0d",
                   want.motor_id, want.updated, got.updated);
            mismatches++;
        end
        if (got.round_end !== want.round_end) begin
            $error("round_end (motor %0d): expected %0d, got %0d",
                   want.motor_id, want.round_end, got.round_end);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            target_q = fmsp_pkg::TARGET_RST;
            limit_q  = fmsp_pkg::LIMIT_RST;
            pgain_q  = fmsp_pkg::PGAIN_RST;
            igain_q  = fmsp_pkg::IGAIN_RST;
            dgain_q  = fmsp_pkg::DGAIN_RST;
            for (int i = 0; i < fmsp_pkg::MOTORS; i++) begin
                last_stamp[i] = '0;
                period_of[i]  = '0;
                integ_of[i]   = 0;
                last_err[i]   = 0;
                duty_of[i]    = '0;
            end
            turn = '0;
            duty_expect_q.delete();
        end else begin
            // register writes; unlisted indexes fall through
            if (cfg_we) begin
                case (cfg_addr)
                    fmsp_pkg::CFG_TARGET: target_q = cfg_wdata[fmsp_pkg::TARGET_BITS-1:0];
                    fmsp_pkg::CFG_LIMIT:  limit_q  = cfg_wdata[fmsp_pkg::LIMIT_BITS-1:0];
                    fmsp_pkg::CFG_PGAIN:  pgain_q  = cfg_wdata[fmsp_pkg::PGAIN_BITS-1:0];
                    fmsp_pkg::CFG_IGAIN:  igain_q  = cfg_wdata[fmsp_pkg::IGAIN_BITS-1:0];
                    fmsp_pkg::CFG_DGAIN:  dgain_q  = cfg_wdata[fmsp_pkg::DGAIN_BITS-1:0];
                    default: ;
                endcase
            end

            // result side first: a result never stems from a word taken this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got_word.motor_id  = m_axis_tdata[fmsp_pkg::MOTOR_BITS-1:0];
                got_word.duty      = m_axis_tdata[fmsp_pkg::MOTOR_BITS +: fmsp_pkg::DUTY_BITS];
                got_word.updated   = m_axis_tuser;
                got_word.round_end = m_axis_tlast;
                if (duty_expect_q.size() == 0) begin
                    $error("result word motor %0d duty %0d with nothing expected",
                           got_word.motor_id, got_word.duty);
                    mismatches++;
                end else begin
                    want_word = duty_expect_q.pop_front();
                    compare_word(got_word, want_word);
                end
            end

            // input side: edges update the period, ticks queue a prediction
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == fmsp_pkg::MODE_TICK) begin
                    duty_expect_q.push_back(serve_tick());
                end else begin
                    period_of[s_axis_tuser[2:1]]  =
                        s_axis_tdata - last_stamp[s_axis_tuser[2:1]];
                    last_stamp[s_axis_tuser[2:1]] = s_axis_tdata;
                end
            end
        end
        results_due = duty_expect_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    // first of the register indexes that map to nothing
    localparam logic [fmsp_pkg::CFG_ADDR_BITS-1:0] CFG_UNUSED_LO = 3'd5;
    // drain phase: total ticks, 40 per motor, driving every integral far negative
    localparam int DRAIN_TICKS = 4 * 40;

    logic                                aclk          = 1'b0;
    logic                                aresetn       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    wire                                 s_axis_tready;
    logic [15:0]                         s_axis_tdata  = '0;  // stamp
    logic [2:0]                          s_axis_tuser  = '0;  // mode, motor_sel
    wire                                 m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    wire [fmsp_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;        // motor_id, duty
    wire                                 m_axis_tuser;        // updated
    wire                                 m_axis_tlast;        // round_end
    logic                                cfg_we        = 1'b0;
    logic [fmsp_pkg::CFG_ADDR_BITS-1:0]  cfg_addr      = '0;
    logic [fmsp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata     = '0;

    int          fail_count;
    int          results_due;
    logic [15:0] sent_stamp [fmsp_pkg::MOTORS];
    int          ready_hold = 0;
    bit          stall_on   = 1'b1;
    bit          burst_on   = 1'b0;

    four_motor_speed_pid_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    speed_pid_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_axis_tready = 1'b0;
            ready_hold    = ready_hold - 1;
        end else begin
            m_axis_tready = 1'b1;
            if (stall_on && $urandom_range(0, 3) == 0)
                ready_hold = pick_gap();
        end
    end

    task automatic send_word(input logic mode, input logic [1:0] sel,
                             input logic [15:0] stamp);
        int gap;
        gap = burst_on ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {sel, mode};
        s_axis_tdata  = stamp;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_edge(input logic [1:0] m, input logic [15:0] stamp);
        send_word(fmsp_pkg::MODE_EDGE, m, stamp);
        sent_stamp[m] = stamp;
    endtask

    // selector and stamp of a tick are don't-care, so they carry noise
    task automatic send_tick();
        send_word(fmsp_pkg::MODE_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (results_due != 0) @(negedge aclk);
    endtask

    // block fully idle: results in, trailing edge words absorbed
    task automatic settle();
        wait_results();
        repeat (50) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [fmsp_pkg::CFG_ADDR_BITS-1:0] addr,
                             input logic [fmsp_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_setting(input logic [fmsp_pkg::CFG_DATA_BITS-1:0] target,
                                 input logic [fmsp_pkg::CFG_DATA_BITS-1:0] limit,
                                 input logic [fmsp_pkg::CFG_DATA_BITS-1:0] pgain,
                                 input logic [fmsp_pkg::CFG_DATA_BITS-1:0] igain,
                                 input logic [fmsp_pkg::CFG_DATA_BITS-1:0] dgain);
        settle();
        cfg_write(CFG_UNUSED_LO + fmsp_pkg::CFG_ADDR_BITS'($urandom_range(0, 2)),
                  fmsp_pkg::CFG_DATA_BITS'($urandom));
        cfg_write(fmsp_pkg::CFG_TARGET, target);
        cfg_write(fmsp_pkg::CFG_LIMIT, limit);
        cfg_write(fmsp_pkg::CFG_PGAIN, pgain);
        cfg_write(fmsp_pkg::CFG_IGAIN, igain);
        cfg_write(fmsp_pkg::CFG_DGAIN, dgain);
        stall_on = 1'b1;
        burst_on = 1'b0;
    endtask

    // mixed ticks and edge words; edge periods mostly near the setpoint
    task automatic run_random(input int count);
        int          c;
        int          p;
        logic [1:0]  m;
        logic [15:0] st;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                burst_on = ($urandom_range(0, 3) == 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) == 0)
                wait_results();
            if ($urandom_range(0, 99) < 45) begin
                send_tick();
            end else begin
                m = 2'($urandom_range(0, 3));
                c = $urandom_range(0, 99);
                if (c < 50)      p = $urandom_range(700, 4000);
                else if (c < 62) p = $urandom_range(1, 300);
                else if (c < 70) p = $urandom_range(15000, 65535);
                else if (c < 74) p = $urandom_range(20195, 20210);
                else if (c < 80) p = 0;
                else             p = -1;
                st = (p < 0) ? 16'($urandom) : sent_stamp[m] + 16'(p);
                send_edge(m, st);
            end
        end
    endtask

    task automatic run_directed();
        // tick before any edge: zero period
        send_tick();
        send_edge(2'd1, 16'hFFFF);
        send_edge(2'd2, 16'd1667);
        send_edge(2'd3, 16'd1);
        // longest period that still counts as moving
        send_edge(2'd0, 16'd20202);
        send_tick();
        send_tick();
        send_tick();
        // one count past it: standing still
        send_edge(2'd0, 16'd40405);
        send_tick();
        // stamp wraps: period of one, far over the limit
        send_edge(2'd1, 16'h0000);
        send_edge(2'd2, 16'd3334);
        send_tick();
        send_tick();
        send_tick();
        // same stamp twice: period back to zero
        send_edge(2'd2, 16'd3334);
        send_tick();
        send_tick();
        // zero setpoint with a stopped motor forces the duty off
        settle();
        cfg_write(fmsp_pkg::CFG_TARGET, '0);
        send_tick();
        send_tick();
        send_tick();
    endtask

    // drive every integral deep negative, zero setpoint and speed near the limit
    task automatic run_drain();
        apply_setting(20'd0, 20'd1048575, 20'd0, 20'd255, 20'd0);
        for (int i = 0; i < fmsp_pkg::MOTORS; i++)
            send_edge(2'(i), sent_stamp[i] + 16'd126);
        stall_on = 1'b0;
        burst_on = 1'b1;
        repeat (DRAIN_TICKS) send_tick();
    endtask

    initial begin
        for (int i = 0; i < fmsp_pkg::MOTORS; i++)
            sent_stamp[i] = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        run_directed();

        apply_setting(20'd78643, 20'd262144, 20'd140, 20'd2, 20'd50);
        run_random(180);
        apply_setting(20'd262143, 20'd1048575, 20'd1023, 20'd255, 20'd255);
        run_random(130);
        apply_setting(20'd0, 20'd1048575, 20'd0, 20'd0, 20'd0);
        run_random(80);
        apply_setting(20'($urandom), 20'($urandom), 20'($urandom),
                      20'($urandom), 20'($urandom));
        run_random(130);
        apply_setting(20'd78643, 20'd0, 20'd140, 20'd2, 20'd50);
        run_random(60);
        apply_setting(20'd131072, 20'd600000, 20'd300, 20'd20, 20'd100);
        run_random(130);
        apply_setting(20'($urandom), 20'($urandom), 20'($urandom),
                      20'($urandom), 20'($urandom));
        run_random(130);
        apply_setting(20'($urandom), 20'($urandom), 20'($urandom),
                      20'($urandom), 20'($urandom));
        run_random(100);

        run_drain();
        settle();

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #(40_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
